FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the encoder angle and speed block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/easu_pkg.sv
// Package with the widths, constants and control types of the encoder angle and speed block.
package easu_pkg;

    localparam int ANGLE_BITS  = 14;
    localparam int MECH_W      = ANGLE_BITS + 1;
    localparam int RAW_W       = 14;
    localparam int OFFSET_W    = 14;
    localparam int POLE_W      = 6;
    localparam int RATE_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int ANGLE_OUT_W = 15;
    localparam int RAD_W       = 16;
    localparam int SPEED_W     = 15;

    localparam int PROD_W   = MECH_W + POLE_W;
    localparam int MAG60_W  = MECH_W + 6;
    localparam int SCALED_W = MAG60_W + RATE_W;
    localparam int Q_W      = SCALED_W + 4;
    localparam int RADP_W   = MECH_W + 32;
    localparam int RAD_SHIFT = 16 + ANGLE_BITS;

    localparam logic [MECH_W-1:0]   FULL_TURN   = MECH_W'(1) << ANGLE_BITS;
    localparam logic [31:0]         TWO_PI_Q29  = 32'd3373259426;
    localparam logic [SCALED_W-1:0] SPEED_LIMIT_SCALED = SCALED_W'(1000) << ANGLE_BITS;
    localparam logic [SPEED_W-1:0]  SPEED_LIMIT_Q4 = SPEED_W'(16000);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_OFFSET   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLE_PAIRS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE_HZ = 2'd2;

    localparam logic [OFFSET_W-1:0] RESET_ANGLE_OFFSET = '0;
    localparam logic [POLE_W-1:0]   RESET_POLE_PAIRS   = POLE_W'(1);
    localparam logic [RATE_W-1:0]   RESET_SAMPLE_RATE  = RATE_W'(1000);

    // Commands from the controller: one load strobe per datapath step.
    typedef struct packed {
        logic load;
        logic mech;
        logic mul;
        logic scale;
        logic rad;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/easu_ctrl.sv
// Controller state machine that sequences one transaction through the datapath steps.
module easu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  easu_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output easu_pkg::t_cmd o_cmd
);
    import easu_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MECH  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SCALE = 3'd3;
    localparam logic [2:0] ST_RAD   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MECH;
                end
            end
            ST_MECH: begin
                o_cmd.mech = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_RAD;
            end
            ST_RAD: begin
                o_cmd.rad = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                // Wait here until the output register is free or being emptied.
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: rtl/easu_dp.sv
// Datapath with angle, multiplier and speed stages plus the result register.
module easu_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  easu_pkg::t_cmd                     i_cmd,
    output easu_pkg::t_sts                     o_sts,
    input  logic [easu_pkg::RAW_W-1:0]         i_raw_angle,
    input  logic [easu_pkg::OFFSET_W-1:0]      i_angle_offset,
    input  logic [easu_pkg::POLE_W-1:0]        i_pole_pairs,
    input  logic [easu_pkg::RATE_W-1:0]        i_sample_rate_hz,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output logic [easu_pkg::ANGLE_OUT_W-1:0]   o_mech_angle,
    output logic [easu_pkg::ANGLE_OUT_W-1:0]   o_elec_angle,
    output logic [easu_pkg::RAD_W-1:0]         o_elec_radians,
    output logic signed [easu_pkg::SPEED_W-1:0] o_speed_rpm
);
    import easu_pkg::*;

    logic [RAW_W-1:0]          r_raw;
    logic [MECH_W-1:0]         r_mech;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_neg;
    logic [MAG60_W-1:0]        r_mag60;
    logic [MECH_W-1:0]         r_elec;
    logic [SCALED_W-1:0]       r_scaled;
    logic [RADP_W-1:0]         r_radp;
    logic signed [SPEED_W-1:0] r_speed;
    logic [MECH_W-1:0]         r_prev_mech;
    logic signed [SPEED_W-1:0] r_prev_speed;
    logic                      r_out_valid;
    logic [ANGLE_OUT_W-1:0]    r_out_mech;
    logic [ANGLE_OUT_W-1:0]    r_out_elec;
    logic [RAD_W-1:0]          r_out_rad;
    logic signed [SPEED_W-1:0] r_out_speed;

    logic [ANGLE_BITS-1:0]     w_wrapped;
    logic [MECH_W-1:0]         w_mag;
    logic                      w_neg;
    logic [PROD_W-1:0]         w_prod_m1;
    logic [MECH_W-1:0]         w_elec;
    logic [Q_W-1:0]            w_q_full;
    logic [SPEED_W-1:0]        w_q_clamp;
    logic signed [SPEED_W-1:0] w_speed;
    logic [RADP_W-1:0]         w_rad_sum;
    logic [RADP_W-1:0]         w_rad_sh;
    logic [RAD_W-1:0]          w_rad;

    // Offset correction wraps modulo one turn; the mirror gives 1..FULL_TURN.
    assign w_wrapped = ANGLE_BITS'(r_raw) - ANGLE_BITS'(i_angle_offset);

    assign w_neg = (r_mech < r_prev_mech);
    assign w_mag = w_neg ? (r_prev_mech - r_mech) : (r_mech - r_prev_mech);

    assign w_prod_m1 = r_prod - PROD_W'(1);
    assign w_elec = (r_prod == '0) ? '0 : (MECH_W'(w_prod_m1[ANGLE_BITS-1:0]) + MECH_W'(1));

    // Rounded 1/16 rpm magnitude; only used when the limit check passes.
    assign w_q_full  = ({r_scaled, 4'b0000} + Q_W'(FULL_TURN >> 1)) >> ANGLE_BITS;
    assign w_q_clamp = (w_q_full > Q_W'(SPEED_LIMIT_Q4)) ? SPEED_LIMIT_Q4
                                                          : w_q_full[SPEED_W-1:0];

    always_comb begin
        if (r_scaled > SPEED_LIMIT_SCALED) begin
            w_speed = r_prev_speed;
        end else if (r_neg) begin
            w_speed = -$signed(w_q_clamp);
        end else begin
            w_speed = $signed(w_q_clamp);
        end
    end

    assign w_rad_sum = r_radp + (RADP_W'(1) << (RAD_SHIFT - 1));
    assign w_rad_sh  = w_rad_sum >> RAD_SHIFT;
    assign w_rad     = (w_rad_sh > RADP_W'({RAD_W{1'b1}})) ? {RAD_W{1'b1}}
                                                            : w_rad_sh[RAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw <= i_raw_angle;
        end
        if (i_cmd.mech) begin
            r_mech <= FULL_TURN - MECH_W'(w_wrapped);
        end
        if (i_cmd.mul) begin
            r_prod  <= PROD_W'(r_mech) * PROD_W'(i_pole_pairs);
            r_neg   <= w_neg;
            r_mag60 <= (MAG60_W'(w_mag) << 6) - (MAG60_W'(w_mag) << 2);
        end
        if (i_cmd.scale) begin
            r_elec   <= w_elec;
            r_scaled <= SCALED_W'(r_mag60) * SCALED_W'(i_sample_rate_hz);
        end
        if (i_cmd.rad) begin
            r_radp  <= RADP_W'(r_elec) * RADP_W'(TWO_PI_Q29);
            r_speed <= w_speed;
        end
        if (i_cmd.fin) begin
            r_out_mech  <= ANGLE_OUT_W'(r_mech);
            r_out_elec  <= ANGLE_OUT_W'(r_elec);
            r_out_rad   <= w_rad;
            r_out_speed <= r_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mech  <= '0;
            r_prev_speed <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_prev_mech  <= r_mech;
                r_prev_speed <= r_speed;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_mech_angle   = r_out_mech;
    assign o_elec_angle   = r_out_elec;
    assign o_elec_radians = r_out_rad;
    assign o_speed_rpm    = r_out_speed;

endmodule

FILE: rtl/encoder_angle_speed_unit_core.sv
// Top level of the encoder angle and speed block: configuration registers, controller, datapath.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one raw 14-bit rotor
// angle per transaction. The output channel (o_out_valid / i_out_stall) returns one
// result per input: mechanical angle, electrical angle, electrical angle in Q3.13
// radians, and mechanical speed in 1/16 rpm.
// One item is in work at a time: the input stays stalled after an item is accepted
// until its result is loaded into the output register. Each item passes through
// a sequence of shared steps (offset and mirror, pole pair and speed pre-scale,
// rate multiply, radian multiply, output load). A finished result sits in the output
// register; the block accepts and works on the next input while it waits, and holds
// that next result in its last step until the receiver takes the previous one by
// dropping i_out_stall.
// The configuration registers (angle offset, pole pairs, sample rate) are written
// through i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only while the
// block is idle, which the block does not enforce. Indexes beyond the list are ignored.
// Synchronous reset restores the register defaults (offset 0, one pole pair,
// 1000 Hz), clears the previous angle and speed to zero and empties the output.
`include "assert_macros.svh"

module encoder_angle_speed_unit_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [easu_pkg::RAW_W-1:0]           i_raw_angle,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [easu_pkg::ANGLE_OUT_W-1:0]     o_mech_angle,
    output logic [easu_pkg::ANGLE_OUT_W-1:0]     o_elec_angle,
    output logic [easu_pkg::RAD_W-1:0]           o_elec_radians,
    output logic signed [easu_pkg::SPEED_W-1:0]  o_speed_rpm,
    input  logic                                 i_cfg_we,
    input  logic [easu_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [easu_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import easu_pkg::*;

    logic [OFFSET_W-1:0] r_angle_offset;
    logic [POLE_W-1:0]   r_pole_pairs;
    logic [RATE_W-1:0]   r_sample_rate_hz;

    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration registers; data is truncated to each register's width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_offset   <= RESET_ANGLE_OFFSET;
            r_pole_pairs     <= RESET_POLE_PAIRS;
            r_sample_rate_hz <= RESET_SAMPLE_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ANGLE_OFFSET: begin
                    r_angle_offset <= i_cfg_data[OFFSET_W-1:0];
                end
                REG_POLE_PAIRS: begin
                    r_pole_pairs <= i_cfg_data[POLE_W-1:0];
                end
                REG_SAMPLE_RATE_HZ: begin
                    r_sample_rate_hz <= i_cfg_data[RATE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The controller steps each transaction through the datapath.
    easu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    easu_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_raw_angle      (i_raw_angle),
        .i_angle_offset   (r_angle_offset),
        .i_pole_pairs     (r_pole_pairs),
        .i_sample_rate_hz (r_sample_rate_hz),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_mech_angle     (o_mech_angle),
        .o_elec_angle     (o_elec_angle),
        .o_elec_radians   (o_elec_radians),
        .o_speed_rpm      (o_speed_rpm)
    );

    // An accepted transaction keeps the input side busy in the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A new result only appears at the end of a transaction that was in work.
    `ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

    // Results stay within their ranges: mechanical angle nonzero, electrical angle at
    // most one turn, speed within the limit.
    `ASSERT_SAME(a_result_range, i_clk, i_rst_n, o_out_valid,
        (o_mech_angle != '0) && (o_elec_angle <= ANGLE_OUT_W'(FULL_TURN))
        && (o_speed_rpm <= $signed(SPEED_LIMIT_Q4))
        && (o_speed_rpm >= -$signed(SPEED_LIMIT_Q4)))

endmodule
